>>> src/sps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper profile step sequencer package
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 24;
  localparam int STEPS_W     = 13;
  localparam int IDX_W       = 12;
  localparam int SPEED_W     = 16;
  localparam int PRE_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = STEPS_W;

  localparam int SPEED_NUM   = 280000;
  localparam int NUM_W       = $clog2(SPEED_NUM + 1);
  localparam int DCNT_W      = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] SPEED_NUM_V = NUM_W'(SPEED_NUM);

  localparam int WIDE_A      = (CNT_W > STEPS_W) ? CNT_W : STEPS_W;
  localparam int WIDE_B      = (ADDR_W + 1 > IDX_W) ? ADDR_W + 1 : IDX_W;
  localparam int CMP_W       = ((WIDE_A > WIDE_B) ? WIDE_A : WIDE_B) + 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL_STEPS = 1'b1;

  typedef enum logic [1:0] {
    FUNC_WR_ACCEL,
    FUNC_WR_DECEL,
    FUNC_START,
    FUNC_STEP
  } func_t;

  typedef enum logic [1:0] {
    CAUSE_NONE,
    CAUSE_HOME,
    CAUSE_FAR,
    CAUSE_OVERRUN
  } cause_t;

  typedef enum logic [1:0] {
    SEG_NONE,
    SEG_ACCEL,
    SEG_DECEL,
    SEG_CRUISE
  } seg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_DIV,
    ST_UPDATE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic latch;
    logic div_start;
    logic update;
    logic out_load;
  } sps_cmd_t;

  typedef struct packed {
    logic ramp_read;
    logic div_done;
    logic out_free;
  } sps_stat_t;

endpackage

>>> src/sps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prescaler divider
// Restoring divider, one quotient bit per cycle: constant numerator over the
// table speed, quotient saturated to the prescaler width.
// ----------------------------------------------------------------------------
module sps_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sps_pkg::SPEED_W-1:0] divisor,
  output logic                        done,
  output logic [sps_pkg::PRE_W-1:0]   quot
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [sps_pkg::DCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [sps_pkg::SPEED_W-1:0]   rem_r, rem_nxt;
  logic [sps_pkg::SPEED_W-1:0]   dvs_r, dvs_nxt;
  logic [sps_pkg::NUM_W-1:0]     q_r, q_nxt;
  logic [sps_pkg::SPEED_W:0]     shifted;
  logic [sps_pkg::SPEED_W:0]     diff;
  logic                          ge;

  assign shifted = {rem_r, sps_pkg::SPEED_NUM_V[cnt_r]};
  assign diff    = shifted - {1'b0, dvs_r};
  // zero divisor yields all ones, which saturates
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = sps_pkg::DCNT_W'(sps_pkg::NUM_W - 1);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[sps_pkg::SPEED_W-1:0] : shifted[sps_pkg::SPEED_W-1:0];
      q_nxt   = {q_r[sps_pkg::NUM_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = (|q_r[sps_pkg::NUM_W-1:sps_pkg::PRE_W]) ? '1 : q_r[sps_pkg::PRE_W-1:0];

endmodule

>>> src/sps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer datapath
// Speed tables, move state, ramp segment decode, step update and the
// result register.
// ----------------------------------------------------------------------------
module sps_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sps_pkg::sps_cmd_t             cmd,
  output sps_pkg::sps_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]                    in_func,
  input  logic [sps_pkg::IDX_W-1:0]     in_table_index,
  input  logic [sps_pkg::SPEED_W-1:0]   in_table_speed,
  input  logic [sps_pkg::CNT_W-1:0]     in_target_pulses,
  input  logic                          in_move_backward,
  input  logic [sps_pkg::PRE_W-1:0]     in_start_prescaler,
  input  logic                          in_home_limit_level,
  input  logic                          in_far_limit_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sps_pkg::PRE_W-1:0]     out_prescaler,
  output logic                          out_running,
  output logic [sps_pkg::CNT_W-1:0]     out_position,
  output logic [sps_pkg::CNT_W-1:0]     out_pulse_count,
  output logic [1:0]                    out_stop_cause
);

  localparam int AW   = sps_pkg::ADDR_W;
  localparam int CW   = sps_pkg::CMP_W;
  localparam int IXW  = (AW > sps_pkg::IDX_W) ? AW : sps_pkg::IDX_W;
  localparam int PXW  = (AW > sps_pkg::CNT_W) ? AW : sps_pkg::CNT_W;

  // configuration
  logic [sps_pkg::STEPS_W-1:0] accel_steps_r, decel_steps_r;

  // latched item
  sps_pkg::func_t              func_r;
  logic [sps_pkg::IDX_W-1:0]   index_r;
  logic [sps_pkg::SPEED_W-1:0] speed_r;
  logic [sps_pkg::CNT_W-1:0]   target_in_r;
  logic                        back_r;
  logic [sps_pkg::PRE_W-1:0]   spre_r;
  logic                        home_r;
  logic                        far_r;

  // move state
  logic [sps_pkg::CNT_W-1:0]   pulses_r, pulses_nxt;
  logic [sps_pkg::CNT_W-1:0]   pos_r, pos_nxt;
  logic [AW-1:0]               dix_r, dix_nxt;
  logic [sps_pkg::PRE_W-1:0]   pre_r, pre_nxt;
  logic                        active_r, active_nxt;
  logic [sps_pkg::CNT_W-1:0]   target_r, target_nxt;
  logic                        dir_r, dir_nxt;
  sps_pkg::cause_t             cause_r, cause_nxt;

  // result register
  logic                        ovalid_r;
  logic [sps_pkg::PRE_W-1:0]   opre_r;
  logic                        orun_r;
  logic [sps_pkg::CNT_W-1:0]   opos_r;
  logic [sps_pkg::CNT_W-1:0]   opulse_r;
  logic [1:0]                  ocause_r;

  // tables
  logic [sps_pkg::SPEED_W-1:0] accel_mem [sps_pkg::TABLE_DEPTH];
  logic [sps_pkg::SPEED_W-1:0] decel_mem [sps_pkg::TABLE_DEPTH];
  logic [sps_pkg::SPEED_W-1:0] acc_q_r, dec_q_r;

  logic [IXW-1:0]              widx;
  logic [PXW-1:0]              pulses_x;
  logic                        wr_ok;
  logic [CW-1:0]               sum_steps;
  logic                        ramp_en, accel_hit, decel_hit, accel_oob, dix_adv;
  sps_pkg::seg_t               seg;
  logic [sps_pkg::SPEED_W-1:0] div_speed;
  logic                        div_done;
  logic [sps_pkg::PRE_W-1:0]   div_quot;
  logic [sps_pkg::CNT_W-1:0]   pulses_inc;
  logic                        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_steps_r <= '0;
      decel_steps_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sps_pkg::CFG_ACCEL_STEPS: accel_steps_r <= cfg_wdata;
        sps_pkg::CFG_DECEL_STEPS: decel_steps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r      <= sps_pkg::func_t'(in_func);
      index_r     <= in_table_index;
      speed_r     <= in_table_speed;
      target_in_r <= in_target_pulses;
      back_r      <= in_move_backward;
      spre_r      <= in_start_prescaler;
      home_r      <= in_home_limit_level;
      far_r       <= in_far_limit_level;
    end
  end

  // segment decode
  assign sum_steps = CW'(accel_steps_r) + CW'(decel_steps_r);
  assign ramp_en   = CW'(target_r) > sum_steps;
  assign accel_hit = (CW'(pulses_r) + CW'(1)) < CW'(accel_steps_r);
  assign decel_hit = CW'(pulses_r) >= (CW'(target_r) - CW'(decel_steps_r));
  assign accel_oob = CW'(pulses_r) >= CW'(sps_pkg::TABLE_DEPTH);
  assign dix_adv   = ((CW'(dix_r) + CW'(1)) < CW'(decel_steps_r)) &&
                     ((CW'(dix_r) + CW'(1)) < CW'(sps_pkg::TABLE_DEPTH));

  always_comb begin
    if (!ramp_en) begin
      seg = sps_pkg::SEG_NONE;
    end else if (accel_hit) begin
      seg = sps_pkg::SEG_ACCEL;
    end else if (decel_hit) begin
      seg = sps_pkg::SEG_DECEL;
    end else begin
      seg = sps_pkg::SEG_CRUISE;
    end
  end

  // table access
  assign widx     = IXW'(index_r);
  assign pulses_x = PXW'(pulses_r);
  assign wr_ok    = CW'(index_r) < CW'(sps_pkg::TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.update && wr_ok && func_r == sps_pkg::FUNC_WR_ACCEL) begin
      accel_mem[widx[AW-1:0]] <= speed_r;
    end
    acc_q_r <= accel_mem[pulses_x[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.update && wr_ok && func_r == sps_pkg::FUNC_WR_DECEL) begin
      decel_mem[widx[AW-1:0]] <= speed_r;
    end
    dec_q_r <= decel_mem[dix_r];
  end

  always_comb begin
    if (seg == sps_pkg::SEG_ACCEL) begin
      div_speed = accel_oob ? '0 : acc_q_r;
    end else begin
      div_speed = dec_q_r;
    end
  end

  sps_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (div_speed),
    .done    (div_done),
    .quot    (div_quot)
  );

  // step update
  assign pulses_inc = (pulses_r != sps_pkg::CNT_MAX) ? pulses_r + 1'b1 : pulses_r;

  always_comb begin
    pulses_nxt = pulses_r;
    pos_nxt    = pos_r;
    dix_nxt    = dix_r;
    pre_nxt    = pre_r;
    active_nxt = active_r;
    target_nxt = target_r;
    dir_nxt    = dir_r;
    cause_nxt  = sps_pkg::CAUSE_NONE;
    case (func_r)
      sps_pkg::FUNC_START: begin
        target_nxt = target_in_r;
        dir_nxt    = back_r;
        pre_nxt    = spre_r;
        active_nxt = 1'b1;
      end
      sps_pkg::FUNC_STEP: begin
        if (active_r) begin
          case (seg)
            sps_pkg::SEG_ACCEL: begin
              pre_nxt = div_quot;
              dix_nxt = '0;
            end
            sps_pkg::SEG_DECEL: begin
              pre_nxt = div_quot;
              if (dix_adv) begin
                dix_nxt = dix_r + 1'b1;
              end
            end
            sps_pkg::SEG_CRUISE: dix_nxt = '0;
            default: ;
          endcase
          pulses_nxt = pulses_inc;
          if (dir_r) begin
            if (pos_r != '0) begin
              pos_nxt = pos_r - 1'b1;
            end
            if (!home_r) begin
              active_nxt = 1'b0;
              pulses_nxt = '0;
              pos_nxt    = '0;
              cause_nxt  = sps_pkg::CAUSE_HOME;
            end
          end else begin
            if (pos_r != sps_pkg::CNT_MAX) begin
              pos_nxt = pos_r + 1'b1;
            end
            if (!far_r) begin
              active_nxt = 1'b0;
              pulses_nxt = '0;
              cause_nxt  = sps_pkg::CAUSE_FAR;
            end
          end
          if (active_nxt && pulses_inc > target_r) begin
            active_nxt = 1'b0;
            pulses_nxt = '0;
            cause_nxt  = sps_pkg::CAUSE_OVERRUN;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulses_r <= '0;
      pos_r    <= '0;
      dix_r    <= '0;
      pre_r    <= '0;
      active_r <= 1'b0;
      target_r <= '0;
      dir_r    <= 1'b0;
      cause_r  <= sps_pkg::CAUSE_NONE;
    end else if (cmd.update) begin
      pulses_r <= pulses_nxt;
      pos_r    <= pos_nxt;
      dix_r    <= dix_nxt;
      pre_r    <= pre_nxt;
      active_r <= active_nxt;
      target_r <= target_nxt;
      dir_r    <= dir_nxt;
      cause_r  <= cause_nxt;
    end
  end

  // result register
  assign out_free = !ovalid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      opre_r   <= pre_r;
      orun_r   <= active_r;
      opos_r   <= pos_r;
      opulse_r <= pulses_r;
      ocause_r <= cause_r;
    end
  end

  assign stat.ramp_read = (func_r == sps_pkg::FUNC_STEP) && active_r &&
                          (seg == sps_pkg::SEG_ACCEL || seg == sps_pkg::SEG_DECEL);
  assign stat.div_done  = div_done;
  assign stat.out_free  = out_free;

  assign out_valid       = ovalid_r;
  assign out_prescaler   = opre_r;
  assign out_running     = orun_r;
  assign out_position    = opos_r;
  assign out_pulse_count = opulse_r;
  assign out_stop_cause  = ocause_r;

endmodule

>>> src/sps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer controller
// Walks one item through decode, update and result; a step in a ramp segment
// also passes through table read and divide.
module sps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sps_pkg::sps_stat_t stat,
  output sps_pkg::sps_cmd_t  cmd
);

  sps_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sps_pkg::ST_IDLE:   if (in_valid) state_nxt = sps_pkg::ST_DECODE;
      sps_pkg::ST_DECODE: state_nxt = stat.ramp_read ? sps_pkg::ST_LOAD : sps_pkg::ST_UPDATE;
      sps_pkg::ST_LOAD:   state_nxt = sps_pkg::ST_DIV;
      sps_pkg::ST_DIV:    if (stat.div_done) state_nxt = sps_pkg::ST_UPDATE;
      sps_pkg::ST_UPDATE: state_nxt = sps_pkg::ST_RESULT;
      sps_pkg::ST_RESULT: if (stat.out_free) state_nxt = sps_pkg::ST_IDLE;
      default:            state_nxt = sps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.latch     = 1'b0;
    cmd.div_start = 1'b0;
    cmd.update    = 1'b0;
    cmd.out_load  = 1'b0;
    case (state_r)
      sps_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      sps_pkg::ST_LOAD:   cmd.div_start = 1'b1;
      sps_pkg::ST_UPDATE: cmd.update = 1'b1;
      sps_pkg::ST_RESULT: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/stepper_profile_step_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper profile step sequencer
// Each input beat is a table write, a move start or a step event; each
// produces one result beat with prescaler, running flag, position, pulse
// count and stop cause.
// Channels: in_* and out_* are valid/ready; cfg_we writes accel_steps
// (index 0) or decel_steps (index 1); the user must write them only while
// idle, and the block itself does not enforce this.
// Path: writes, starts, idle steps and cruise steps go from accept through
// decode, update and result to out_valid; a step in a ramp segment also
// passes the table read and the one-bit-per-cycle prescaler divider.
// Flow: one item at a time; in_ready returns the cycle after the result is
// loaded into the output register, so one beat can wait at the output while
// the next is accepted and processed.
// Stall: if out_ready stays low, the next finished result holds inside until
// the output register empties; no beat is dropped.
// Reset: synchronous rst_n clears counters, move state and config; the
// speed tables are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module stepper_profile_step_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_func,
  input  logic [sps_pkg::IDX_W-1:0]      in_table_index,
  input  logic [sps_pkg::SPEED_W-1:0]    in_table_speed,
  input  logic [sps_pkg::CNT_W-1:0]      in_target_pulses,
  input  logic                           in_move_backward,
  input  logic [sps_pkg::PRE_W-1:0]      in_start_prescaler,
  input  logic                           in_home_limit_level,
  input  logic                           in_far_limit_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sps_pkg::PRE_W-1:0]      out_prescaler,
  output logic                           out_running,
  output logic [sps_pkg::CNT_W-1:0]      out_position,
  output logic [sps_pkg::CNT_W-1:0]      out_pulse_count,
  output logic [1:0]                     out_stop_cause
);

  sps_pkg::sps_cmd_t  cmd;
  sps_pkg::sps_stat_t stat;

  sps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sps_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_func             (in_func),
    .in_table_index      (in_table_index),
    .in_table_speed      (in_table_speed),
    .in_target_pulses    (in_target_pulses),
    .in_move_backward    (in_move_backward),
    .in_start_prescaler  (in_start_prescaler),
    .in_home_limit_level (in_home_limit_level),
    .in_far_limit_level  (in_far_limit_level),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_prescaler       (out_prescaler),
    .out_running         (out_running),
    .out_position        (out_position),
    .out_pulse_count     (out_pulse_count),
    .out_stop_cause      (out_stop_cause)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in progress");

  a_stop_not_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stop_cause != sps_pkg::CAUSE_NONE) |->
    (!out_running && out_pulse_count == '0))
    else $error("stopped move still running or counting");

  a_home_zeroes_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stop_cause == sps_pkg::CAUSE_HOME) |-> (out_position == '0))
    else $error("home stop with nonzero position");

  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> !cmd.out_load)
    else $error("result loaded twice for one item");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper profile step sequencer testbench
// Drives table writes, move starts and step events with random gaps and
// output stalls. A local ramp model predicts each result beat, and every
// result is compared field by field in arrival order. Each ramp read is
// preceded by a write to that table entry if the entry is still unwritten.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TOTAL_BEATS  = 1350;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_CYCLES = 300;

  typedef struct packed {
    sps_pkg::func_t                func;
    logic [sps_pkg::IDX_W-1:0]     table_index;
    logic [sps_pkg::SPEED_W-1:0]   table_speed;
    logic [sps_pkg::CNT_W-1:0]     target_pulses;
    logic                          move_backward;
    logic [sps_pkg::PRE_W-1:0]     start_prescaler;
    logic                          home_limit_level;
    logic                          far_limit_level;
  } move_cmd_t;

  typedef struct packed {
    logic [sps_pkg::PRE_W-1:0] prescaler;
    logic                      running;
    logic [sps_pkg::CNT_W-1:0] position;
    logic [sps_pkg::CNT_W-1:0] pulse_count;
    sps_pkg::cause_t           stop_cause;
  } motion_status_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     in_func = '0;
  logic [sps_pkg::IDX_W-1:0]      in_table_index = '0;
  logic [sps_pkg::SPEED_W-1:0]    in_table_speed = '0;
  logic [sps_pkg::CNT_W-1:0]      in_target_pulses = '0;
  logic                           in_move_backward = 1'b0;
  logic [sps_pkg::PRE_W-1:0]      in_start_prescaler = '0;
  logic                           in_home_limit_level = 1'b1;
  logic                           in_far_limit_level = 1'b1;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [sps_pkg::PRE_W-1:0]      out_prescaler;
  logic                           out_running;
  logic [sps_pkg::CNT_W-1:0]      out_position;
  logic [sps_pkg::CNT_W-1:0]      out_pulse_count;
  logic [1:0]                     out_stop_cause;

  // ramp model state
  logic [sps_pkg::SPEED_W-1:0] accel_speed [sps_pkg::TABLE_DEPTH];
  logic [sps_pkg::SPEED_W-1:0] decel_speed [sps_pkg::TABLE_DEPTH];
  bit                          accel_written [sps_pkg::TABLE_DEPTH];
  bit                          decel_written [sps_pkg::TABLE_DEPTH];
  logic [sps_pkg::STEPS_W-1:0] accel_steps_q = '0;
  logic [sps_pkg::STEPS_W-1:0] decel_steps_q = '0;
  logic [sps_pkg::CNT_W-1:0]   pulses_q = '0;
  logic [sps_pkg::CNT_W-1:0]   position_q = '0;
  logic [sps_pkg::IDX_W-1:0]   decel_idx_q = '0;
  logic [sps_pkg::PRE_W-1:0]   prescaler_q = '0;
  logic                        active_q = 1'b0;
  logic [sps_pkg::CNT_W-1:0]   target_q = '0;
  logic                        backward_q = 1'b0;

  motion_status_t expected_status_q [$];
  int             mismatches = 0;
  int             beats_sent = 0;
  int             hold_cycles = 0;
  bit             gaps_on = 1'b1;

  stepper_profile_step_sequencer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_table_index      (in_table_index),
    .in_table_speed      (in_table_speed),
    .in_target_pulses    (in_target_pulses),
    .in_move_backward    (in_move_backward),
    .in_start_prescaler  (in_start_prescaler),
    .in_home_limit_level (in_home_limit_level),
    .in_far_limit_level  (in_far_limit_level),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_prescaler       (out_prescaler),
    .out_running         (out_running),
    .out_position        (out_position),
    .out_pulse_count     (out_pulse_count),
    .out_stop_cause      (out_stop_cause)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [sps_pkg::PRE_W-1:0] prescaler_for_speed(
    input logic [sps_pkg::SPEED_W-1:0] speed);
    int q;
    if (speed == '0) return '1;
    q = sps_pkg::SPEED_NUM / int'(speed);
    return (q > 65535) ? '1 : q[sps_pkg::PRE_W-1:0];
  endfunction

  function automatic sps_pkg::seg_t ramp_segment();
    int p;
    int tgt;
    int acc;
    int dec;
    p   = int'(pulses_q);
    tgt = int'(target_q);
    acc = int'(accel_steps_q);
    dec = int'(decel_steps_q);
    if (tgt <= acc + dec) return sps_pkg::SEG_NONE;
    if (p + 1 < acc) return sps_pkg::SEG_ACCEL;
    if (p >= tgt - dec) return sps_pkg::SEG_DECEL;
    return sps_pkg::SEG_CRUISE;
  endfunction

  function automatic motion_status_t sequencer_step(input move_cmd_t c);
    motion_status_t  r;
    sps_pkg::cause_t cause;
    int              di;
    int              dec;
    cause = sps_pkg::CAUSE_NONE;
    case (c.func)
      sps_pkg::FUNC_WR_ACCEL: begin
        accel_speed[c.table_index]   = c.table_speed;
        accel_written[c.table_index] = 1'b1;
      end
      sps_pkg::FUNC_WR_DECEL: begin
        decel_speed[c.table_index]   = c.table_speed;
        decel_written[c.table_index] = 1'b1;
      end
      sps_pkg::FUNC_START: begin
        target_q    = c.target_pulses;
        backward_q  = c.move_backward;
        prescaler_q = c.start_prescaler;
        active_q    = 1'b1;
      end
      default: begin
        if (active_q) begin
          case (ramp_segment())
            sps_pkg::SEG_ACCEL: begin
              if (pulses_q < sps_pkg::TABLE_DEPTH) begin
                prescaler_q =
                  prescaler_for_speed(accel_speed[pulses_q[sps_pkg::IDX_W-1:0]]);
              end else begin
                prescaler_q = prescaler_for_speed('0);
              end
              decel_idx_q = '0;
            end
            sps_pkg::SEG_DECEL: begin
              prescaler_q = prescaler_for_speed(decel_speed[decel_idx_q]);
              di  = int'(decel_idx_q);
              dec = int'(decel_steps_q);
              if (di + 1 < dec && di + 1 < sps_pkg::TABLE_DEPTH) begin
                decel_idx_q = decel_idx_q + 1'b1;
              end
            end
            sps_pkg::SEG_CRUISE: decel_idx_q = '0;
            default: ;
          endcase
          if (pulses_q != sps_pkg::CNT_MAX) pulses_q = pulses_q + 1'b1;
          if (backward_q) begin
            if (position_q != '0) position_q = position_q - 1'b1;
            if (!c.home_limit_level) begin
              active_q   = 1'b0;
              pulses_q   = '0;
              position_q = '0;
              cause      = sps_pkg::CAUSE_HOME;
            end
          end else begin
            if (position_q != sps_pkg::CNT_MAX) position_q = position_q + 1'b1;
            if (!c.far_limit_level) begin
              active_q = 1'b0;
              pulses_q = '0;
              cause    = sps_pkg::CAUSE_FAR;
            end
          end
          if (active_q && pulses_q > target_q) begin
            active_q = 1'b0;
            pulses_q = '0;
            cause    = sps_pkg::CAUSE_OVERRUN;
          end
        end
      end
    endcase
    r.prescaler   = prescaler_q;
    r.running     = active_q;
    r.position    = position_q;
    r.pulse_count = pulses_q;
    r.stop_cause  = cause;
    return r;
  endfunction

  function automatic logic [sps_pkg::SPEED_W-1:0] rand_speed();
    case ($urandom_range(0, 5))
      0: return sps_pkg::SPEED_W'($urandom_range(0, 5));
      1: return '1;
      2: return sps_pkg::SPEED_W'($urandom_range(5, 300));
      default: return sps_pkg::SPEED_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [sps_pkg::CNT_W-1:0] pick_target();
    int span;
    span = int'(accel_steps_q) + int'(decel_steps_q);
    case ($urandom_range(0, 9))
      0: return sps_pkg::CNT_W'($urandom_range(0, span));
      1: return $urandom_range(0, 1) ? sps_pkg::CNT_MAX : '0;
      2: return sps_pkg::CNT_W'($urandom_range(0, 24'hFFFFFF));
      default: return sps_pkg::CNT_W'(span + int'($urandom_range(1, 24)));
    endcase
  endfunction

  function automatic move_cmd_t random_cmd(input sps_pkg::func_t f);
    move_cmd_t c;
    c.func             = f;
    c.table_index      = sps_pkg::IDX_W'($urandom_range(0, sps_pkg::TABLE_DEPTH - 1));
    c.table_speed      = sps_pkg::SPEED_W'($urandom_range(0, 65535));
    c.target_pulses    = sps_pkg::CNT_W'($urandom_range(0, 24'hFFFFFF));
    c.move_backward    = 1'($urandom_range(0, 1));
    c.start_prescaler  = sps_pkg::PRE_W'($urandom_range(0, 65535));
    c.home_limit_level = 1'($urandom_range(0, 1));
    c.far_limit_level  = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic send_beat(input move_cmd_t c);
    while (gaps_on && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    expected_status_q.push_back(sequencer_step(c));
    beats_sent++;
    in_valid            <= 1'b1;
    in_func             <= c.func;
    in_table_index      <= c.table_index;
    in_table_speed      <= c.table_speed;
    in_target_pulses    <= c.target_pulses;
    in_move_backward    <= c.move_backward;
    in_start_prescaler  <= c.start_prescaler;
    in_home_limit_level <= c.home_limit_level;
    in_far_limit_level  <= c.far_limit_level;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_write(input sps_pkg::func_t f, input logic [sps_pkg::IDX_W-1:0] idx,
                            input logic [sps_pkg::SPEED_W-1:0] speed);
    move_cmd_t c;
    c             = random_cmd(f);
    c.table_index = idx;
    c.table_speed = speed;
    send_beat(c);
  endtask

  task automatic send_start(input logic [sps_pkg::CNT_W-1:0] target, input logic back,
                            input logic [sps_pkg::PRE_W-1:0] pre);
    move_cmd_t c;
    c                 = random_cmd(sps_pkg::FUNC_START);
    c.target_pulses   = target;
    c.move_backward   = back;
    c.start_prescaler = pre;
    send_beat(c);
  endtask

  // write the table entry first if the coming ramp read would hit an unwritten one
  task automatic send_step(input logic home_lvl, input logic far_lvl);
    move_cmd_t c;
    if (active_q) begin
      case (ramp_segment())
        sps_pkg::SEG_ACCEL:
          if (pulses_q < sps_pkg::TABLE_DEPTH &&
              !accel_written[pulses_q[sps_pkg::IDX_W-1:0]])
            send_write(sps_pkg::FUNC_WR_ACCEL, pulses_q[sps_pkg::IDX_W-1:0], rand_speed());
        sps_pkg::SEG_DECEL: if (!decel_written[decel_idx_q])
          send_write(sps_pkg::FUNC_WR_DECEL, decel_idx_q, rand_speed());
        default: ;
      endcase
    end
    c                  = random_cmd(sps_pkg::FUNC_STEP);
    c.home_limit_level = home_lvl;
    c.far_limit_level  = far_lvl;
    send_beat(c);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ramp_lengths(input logic [sps_pkg::STEPS_W-1:0] acc,
                                    input logic [sps_pkg::STEPS_W-1:0] dec);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sps_pkg::CFG_ACCEL_STEPS;
    cfg_wdata <= acc;
    @(posedge clk);
    cfg_index <= sps_pkg::CFG_DECEL_STEPS;
    cfg_wdata <= dec;
    @(posedge clk);
    cfg_we <= 1'b0;
    accel_steps_q = acc;
    decel_steps_q = dec;
  endtask

  task automatic run_move(input logic [sps_pkg::CNT_W-1:0] target);
    int   steps;
    int   r;
    logic home_lvl;
    logic far_lvl;
    logic trip;
    steps = 0;
    send_start(target, 1'($urandom_range(0, 1)), sps_pkg::PRE_W'($urandom_range(0, 65535)));
    while (active_q) begin
      r = int'($urandom_range(0, 99));
      if (r < 3) begin
        send_write($urandom_range(0, 1) ? sps_pkg::FUNC_WR_DECEL : sps_pkg::FUNC_WR_ACCEL,
                   sps_pkg::IDX_W'($urandom_range(0, sps_pkg::TABLE_DEPTH - 1)),
                   rand_speed());
      end else if (r < 5) begin
        send_start(pick_target(), 1'($urandom_range(0, 1)),
                   sps_pkg::PRE_W'($urandom_range(0, 65535)));
      end else begin
        home_lvl = 1'($urandom_range(0, 1));
        far_lvl  = 1'($urandom_range(0, 1));
        trip     = (steps >= 40) || ($urandom_range(0, 99) < 3);
        if (backward_q) home_lvl = !trip;
        else far_lvl = !trip;
        send_step(home_lvl, far_lvl);
        steps++;
      end
    end
    if ($urandom_range(0, 4) == 0)
      send_step(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_idle_step();
    send_step(1'b1, 1'b1);
    send_step(1'b0, 1'b0);
  endtask

  task automatic test_table_writes();
    send_write(sps_pkg::FUNC_WR_ACCEL, sps_pkg::IDX_W'(0), 16'd0);
    send_write(sps_pkg::FUNC_WR_ACCEL, sps_pkg::IDX_W'(1), 16'd5);
    send_write(sps_pkg::FUNC_WR_DECEL, sps_pkg::IDX_W'(0), 16'hFFFF);
    send_write(sps_pkg::FUNC_WR_DECEL, sps_pkg::IDX_W'(1), 16'd4);
    send_write(sps_pkg::FUNC_WR_ACCEL, sps_pkg::IDX_W'(sps_pkg::TABLE_DEPTH - 1), 16'd3);
    send_write(sps_pkg::FUNC_WR_DECEL, sps_pkg::IDX_W'(sps_pkg::TABLE_DEPTH - 1), 16'd1);
  endtask

  task automatic test_stop_causes();
    send_start('0, 1'b0, 16'hFFFF);
    send_step(1'b1, 1'b1);
    send_start('0, 1'b1, 16'h0000);
    send_step(1'b0, 1'b1);
    send_start(sps_pkg::CNT_MAX, 1'b0, 16'h5A5A);
    send_step(1'b1, 1'b1);
    send_start(24'd3, 1'b1, 16'hA5A5);
    send_step(1'b1, 1'b0);
    send_start(24'd7, 1'b0, 16'd1);
    send_step(1'b1, 1'b0);
  endtask

  task automatic test_ramp_profile();
    drain_results();
    write_ramp_lengths(13'd3, 13'd2);
    send_start(24'd6, 1'b0, 16'd1234);
    repeat (7) send_step(1'b1, 1'b1);
  endtask

  task automatic test_extreme_ramps();
    drain_results();
    write_ramp_lengths(sps_pkg::STEPS_W'(sps_pkg::TABLE_DEPTH),
                       sps_pkg::STEPS_W'(sps_pkg::TABLE_DEPTH));
    send_start(sps_pkg::CNT_W'(2 * sps_pkg::TABLE_DEPTH + 1), 1'b1, 16'hFFFF);
    send_step(1'b1, 1'b1);
    send_step(1'b0, 1'b1);
    drain_results();
    write_ramp_lengths('0, '0);
  endtask

  task automatic test_backpressure();
    drain_results();
    write_ramp_lengths(13'd2, 13'd3);
    hold_cycles = STALL_CYCLES;
    run_move(24'd13);
    drain_results();
  endtask

  task automatic test_random_moves();
    int acc;
    int dec;
    while (beats_sent < TOTAL_BEATS) begin
      gaps_on = !(beats_sent >= 600 && beats_sent < 800);
      drain_results();
      if ($urandom_range(0, 9) == 0) begin
        acc = int'($urandom_range(0, sps_pkg::TABLE_DEPTH));
        dec = int'($urandom_range(0, sps_pkg::TABLE_DEPTH));
      end else begin
        acc = int'($urandom_range(0, 12));
        dec = int'($urandom_range(0, 12));
      end
      write_ramp_lengths(sps_pkg::STEPS_W'(acc), sps_pkg::STEPS_W'(dec));
      repeat ($urandom_range(1, 3)) run_move(pick_target());
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      out_ready <= !(gaps_on && $urandom_range(0, 99) < 34);
    end
  end

  always @(posedge clk) begin : status_check
    motion_status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status_q.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatches++;
      end else begin
        want = expected_status_q.pop_front();
        if (out_prescaler !== want.prescaler) begin
          $error("prescaler: expected %0d, actual %0d", want.prescaler, out_prescaler);
          mismatches++;
        end
        if (out_running !== want.running) begin
          $error("running: expected %0d, actual %0d", want.running, out_running);
          mismatches++;
        end
        if (out_position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_position);
          mismatches++;
        end
        if (out_pulse_count !== want.pulse_count) begin
          $error("pulse_count: expected %0d, actual %0d", want.pulse_count, out_pulse_count);
          mismatches++;
        end
        if (out_stop_cause !== want.stop_cause) begin
          $error("stop_cause: expected %0d, actual %0d", want.stop_cause, out_stop_cause);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_step();
    test_table_writes();
    test_stop_causes();
    test_ramp_profile();
    test_extreme_ramps();
    test_backpressure();
    test_random_moves();
    drain_results();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> stepper_profile_step_sequencer.f
src/sps_pkg.sv
src/sps_div.sv
src/sps_dp.sv
src/sps_ctrl.sv
src/stepper_profile_step_sequencer.sv
tb/sv/tb_top.sv
